### src/sbie_pkg.sv
// ----------------------------------------------------------------------------
// sbie_pkg: shared types and constants
// opcodes, fault codes, payload words and sequencer states
// ----------------------------------------------------------------------------
package sbie_pkg;

  localparam int STACK_DEPTH_DEF  = 64;
  localparam int LOCALS_DEPTH_DEF = 256;
  localparam logic [7:0] LOAD_BASE   = 8'd26;
  localparam logic [7:0] STORE_BASE  = 8'd59;
  localparam logic [7:0] ICONST_BIAS = 8'd3;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_DIV0  = 3'd1;
  localparam logic [2:0] FLT_STACK = 3'd2;
  localparam logic [2:0] FLT_LOCAL = 3'd3;
  localparam logic [2:0] FLT_OPC   = 3'd4;

  localparam logic CFG_STACK_LIMIT  = 1'b0;
  localparam logic CFG_LOCALS_LIMIT = 1'b1;

  localparam logic [7:0] OP_ICONST_M1 = 8'h02;
  localparam logic [7:0] OP_ICONST_5  = 8'h08;
  localparam logic [7:0] OP_ILOAD_0   = 8'h1a;
  localparam logic [7:0] OP_ILOAD_3   = 8'h1d;
  localparam logic [7:0] OP_ISTORE_0  = 8'h3b;
  localparam logic [7:0] OP_ISTORE_3  = 8'h3e;
  localparam logic [7:0] OP_IFEQ      = 8'h99;
  localparam logic [7:0] OP_IFLE      = 8'h9e;
  localparam logic [7:0] OP_IF_ICMPEQ = 8'h9f;
  localparam logic [7:0] OP_IF_ICMPLE = 8'ha4;
  localparam logic [7:0] OP_ILOAD    = 8'h15;
  localparam logic [7:0] OP_ISTORE   = 8'h36;
  localparam logic [7:0] OP_BIPUSH   = 8'h10;
  localparam logic [7:0] OP_SIPUSH   = 8'h11;
  localparam logic [7:0] OP_IADD     = 8'h60;
  localparam logic [7:0] OP_ISUB     = 8'h64;
  localparam logic [7:0] OP_IMUL     = 8'h68;
  localparam logic [7:0] OP_IDIV     = 8'h6c;
  localparam logic [7:0] OP_IREM     = 8'h70;
  localparam logic [7:0] OP_INEG     = 8'h74;
  localparam logic [7:0] OP_ISHL     = 8'h78;
  localparam logic [7:0] OP_ISHR     = 8'h7a;
  localparam logic [7:0] OP_IUSHR    = 8'h7c;
  localparam logic [7:0] OP_IAND     = 8'h7e;
  localparam logic [7:0] OP_IOR      = 8'h80;
  localparam logic [7:0] OP_IXOR     = 8'h82;
  localparam logic [7:0] OP_IINC     = 8'h84;
  localparam logic [7:0] OP_GOTO     = 8'ha7;
  localparam logic [7:0] OP_IRETURN  = 8'hac;
  localparam logic [7:0] OP_RETURN   = 8'hb1;
  localparam logic [7:0] OP_GETSTAT  = 8'hb2;
  localparam logic [7:0] OP_INVVIRT  = 8'hb6;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand_hi;
    logic [7:0] operand_lo;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pc_offset;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               finished;
    logic               has_return;
    logic signed [31:0] return_value;
    logic [2:0]         fault;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a word
    ST_RD1,    // registered reads of top and top-1 return
    ST_EXEC,   // decode and execute; idiv and irem start the divider
    ST_DIV,    // restoring divider iterations
    ST_DONE    // result held for the consumer
  } state_t;

endpackage

### src/stack_bytecode_int_execute.sv
// ----------------------------------------------------------------------------
// stack_bytecode_int_execute: integer bytecode execution unit
// one instruction per input word, one result word per instruction
// ----------------------------------------------------------------------------
// After reset the block sweeps both the operand stack RAM and the locals RAM
// to zero, one entry per cycle until max(STACK_DEPTH, LOCALS_DEPTH) entries
// (256 by default) are cleared; in_ready stays low until the sweep is done.
// After a word is accepted, ST_RD1 does the registered RAM reads and ST_EXEC
// the shared ALU step into the result register; idiv and irem then pass
// through ST_DIV, a one-bit-per-cycle restoring divider. The result
// sits in an output register and the next word is accepted in the cycle after
// it is taken, so no new word is taken while an instruction is in flight or
// while its result waits for out_ready.
// ----------------------------------------------------------------------------
module stack_bytecode_int_execute #(
  parameter int STACK_DEPTH  = sbie_pkg::STACK_DEPTH_DEF,
  parameter int LOCALS_DEPTH = sbie_pkg::LOCALS_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sbie_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sbie_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data
);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int LAW = $clog2(LOCALS_DEPTH);
  localparam int LLW = $clog2(LOCALS_DEPTH + 1);
  localparam int MAXD = (STACK_DEPTH > LOCALS_DEPTH) ? STACK_DEPTH : LOCALS_DEPTH;
  localparam int CW = $clog2(MAXD + 1);

  sbie_pkg::state_t state_r, state_nxt;

  logic [6:0]     stack_limit_r;
  logic [8:0]     locals_limit_r;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [CW-1:0]  clr_r;
  logic           clearing;
  sbie_pkg::in_word_t ins_r;
  sbie_pkg::out_word_t res_r, res_nxt;

  // divider state
  logic [31:0] dq_r, dq_nxt;     // dividend shifting into quotient
  logic [31:0] drem_r, drem_nxt; // partial remainder
  logic [31:0] dden_r;           // |divisor|
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        qneg_r, rneg_r;

  // RAM ports
  logic           s_we, l_we;
  logic [SAW-1:0] s_waddr, s_ra, s_rb;
  logic [LAW-1:0] l_waddr, l_ra;
  logic [31:0]    s_wdata, l_wdata, s_top, s_nxt, l_rd, l_unused;

  assign clearing = (clr_r != CW'(MAXD));

  // effective limits
  logic [SPW-1:0] lim;
  logic [LLW-1:0] llim;
  always_comb begin
    lim  = (32'(stack_limit_r) < STACK_DEPTH) ? SPW'(stack_limit_r) : SPW'(STACK_DEPTH);
    llim = (32'(locals_limit_r) < LOCALS_DEPTH) ? LLW'(locals_limit_r)
                                                : LLW'(LOCALS_DEPTH);
  end

  sbie_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr_a(s_ra), .rdata_a(s_top), .raddr_b(s_rb), .rdata_b(s_nxt)
  );
  sbie_ram #(.WIDTH(32), .DEPTH(LOCALS_DEPTH)) u_locals (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr_a(l_ra), .rdata_a(l_rd), .raddr_b(l_ra), .rdata_b(l_unused)
  );

  // decode of the held instruction
  logic [7:0]  op, hi, lo;
  logic [15:0] off16;
  logic [8:0]  lidx;
  always_comb begin
    op = ins_r.opcode; hi = ins_r.operand_hi; lo = ins_r.operand_lo;
    off16 = {hi, lo};
    if (op == sbie_pkg::OP_ILOAD || op == sbie_pkg::OP_ISTORE || op == sbie_pkg::OP_IINC)
      lidx = {1'b0, hi};
    else if (op >= sbie_pkg::OP_ILOAD_0 && op <= sbie_pkg::OP_ILOAD_3)
      lidx = {1'b0, op - sbie_pkg::LOAD_BASE};
    else
      lidx = {1'b0, op - sbie_pkg::STORE_BASE};
  end

  // read addresses: top and top-1 of the current stack, local by index
  always_comb begin
    s_ra = SAW'(sp_r - SPW'(1));
    s_rb = SAW'(sp_r - SPW'(2));
    l_ra = LAW'(lidx);
  end

  // shared ALU
  logic [31:0] alu_res;
  logic [31:0] mul;
  always_comb begin
    mul = s_nxt * s_top;
    case (op)
      sbie_pkg::OP_IADD:  alu_res = s_nxt + s_top;
      sbie_pkg::OP_ISUB:  alu_res = s_nxt - s_top;
      sbie_pkg::OP_IMUL:  alu_res = mul;
      sbie_pkg::OP_ISHL:  alu_res = s_nxt << s_top[4:0];
      sbie_pkg::OP_ISHR:  alu_res = 32'($signed(s_nxt) >>> s_top[4:0]);
      sbie_pkg::OP_IUSHR: alu_res = s_nxt >> s_top[4:0];
      sbie_pkg::OP_IAND:  alu_res = s_nxt & s_top;
      sbie_pkg::OP_IOR:   alu_res = s_nxt | s_top;
      sbie_pkg::OP_IXOR:  alu_res = s_nxt ^ s_top;
      sbie_pkg::OP_INEG:  alu_res = 32'd0 - s_top;
      default:            alu_res = s_nxt + l_rd;
    endcase
  end

  // branch compare
  logic tk;
  logic signed [31:0] ca, cb;
  logic [2:0] cc;
  always_comb begin
    if (op >= sbie_pkg::OP_IF_ICMPEQ) begin
      ca = s_nxt; cb = s_top; cc = 3'(op - sbie_pkg::OP_IF_ICMPEQ);
    end else begin
      ca = s_top; cb = '0; cc = 3'(op - sbie_pkg::OP_IFEQ);
    end
    case (cc)
      3'd0:    tk = (ca == cb);
      3'd1:    tk = (ca != cb);
      3'd2:    tk = (ca < cb);
      3'd3:    tk = (ca >= cb);
      3'd4:    tk = (ca > cb);
      default: tk = (ca <= cb);
    endcase
  end

  // divider step
  logic [32:0] dtrial;
  always_comb begin
    dtrial = {drem_r, dq_r[31]} - {1'b0, dden_r};
  end

  always_comb begin
    state_nxt = state_r;
    sp_nxt = sp_r;
    res_nxt = res_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dcnt_nxt = dcnt_r;
    s_we = 1'b0; s_waddr = SAW'(clr_r); s_wdata = '0;
    l_we = 1'b0; l_waddr = LAW'(clr_r); l_wdata = '0;
    in_ready = 1'b0;
    if (clearing) begin
      s_we = (32'(clr_r) < STACK_DEPTH);
      l_we = (32'(clr_r) < LOCALS_DEPTH);
    end
    case (state_r)
      sbie_pkg::ST_IDLE: begin
        in_ready = !clearing;
        if (in_valid && !clearing) state_nxt = sbie_pkg::ST_RD1;
      end
      sbie_pkg::ST_RD1: state_nxt = sbie_pkg::ST_EXEC;
      sbie_pkg::ST_EXEC: begin
        res_nxt = '0;
        state_nxt = sbie_pkg::ST_DONE;
        s_waddr = SAW'(sp_r);
        l_waddr = LAW'(lidx);
        if (op >= sbie_pkg::OP_ICONST_M1 && op <= sbie_pkg::OP_ICONST_5
            || op == sbie_pkg::OP_BIPUSH || op == sbie_pkg::OP_SIPUSH) begin
          if (sp_r >= lim) res_nxt.fault = sbie_pkg::FLT_STACK;
          else begin
            s_we = 1'b1; sp_nxt = sp_r + SPW'(1);
            if (op == sbie_pkg::OP_BIPUSH) begin
              s_wdata = {{24{hi[7]}}, hi}; res_nxt.pc_offset = 16'sd2;
            end else if (op == sbie_pkg::OP_SIPUSH) begin
              s_wdata = {{16{hi[7]}}, off16}; res_nxt.pc_offset = 16'sd3;
            end else begin
              s_wdata = 32'(op) - 32'(sbie_pkg::ICONST_BIAS); res_nxt.pc_offset = 16'sd1;
            end
          end
        end else if (op == sbie_pkg::OP_ILOAD
                     || (op >= sbie_pkg::OP_ILOAD_0 && op <= sbie_pkg::OP_ILOAD_3)) begin
          if (sp_r >= lim) res_nxt.fault = sbie_pkg::FLT_STACK;
          else if (LLW'(lidx) >= llim || lidx >= 9'(LOCALS_DEPTH))
            res_nxt.fault = sbie_pkg::FLT_LOCAL;
          else begin
            s_we = 1'b1; s_wdata = l_rd; sp_nxt = sp_r + SPW'(1);
            res_nxt.pc_offset = (op == sbie_pkg::OP_ILOAD) ? 16'sd2 : 16'sd1;
          end
        end else if (op == sbie_pkg::OP_ISTORE
                     || (op >= sbie_pkg::OP_ISTORE_0 && op <= sbie_pkg::OP_ISTORE_3)) begin
          if (sp_r < SPW'(1)) res_nxt.fault = sbie_pkg::FLT_STACK;
          else if (LLW'(lidx) >= llim || lidx >= 9'(LOCALS_DEPTH))
            res_nxt.fault = sbie_pkg::FLT_LOCAL;
          else begin
            l_we = 1'b1; l_wdata = s_top; sp_nxt = sp_r - SPW'(1);
            res_nxt.pc_offset = (op == sbie_pkg::OP_ISTORE) ? 16'sd2 : 16'sd1;
          end
        end else if (op == sbie_pkg::OP_IINC) begin
          if (LLW'(lidx) >= llim || lidx >= 9'(LOCALS_DEPTH))
            res_nxt.fault = sbie_pkg::FLT_LOCAL;
          else begin
            l_we = 1'b1; l_wdata = l_rd + {{24{lo[7]}}, lo}; res_nxt.pc_offset = 16'sd3;
          end
        end else if (op == sbie_pkg::OP_IDIV || op == sbie_pkg::OP_IREM) begin
          if (sp_r < SPW'(2)) res_nxt.fault = sbie_pkg::FLT_STACK;
          else if (s_top == 32'd0) res_nxt.fault = sbie_pkg::FLT_DIV0;
          else begin
            dq_nxt = s_nxt[31] ? 32'd0 - s_nxt : s_nxt;
            drem_nxt = '0; dcnt_nxt = 6'd0;
            state_nxt = sbie_pkg::ST_DIV;
          end
        end else if (op == sbie_pkg::OP_IADD || op == sbie_pkg::OP_ISUB
                     || op == sbie_pkg::OP_IMUL || op == sbie_pkg::OP_ISHL
                     || op == sbie_pkg::OP_ISHR || op == sbie_pkg::OP_IUSHR
                     || op == sbie_pkg::OP_IAND || op == sbie_pkg::OP_IOR
                     || op == sbie_pkg::OP_IXOR) begin
          if (sp_r < SPW'(2)) res_nxt.fault = sbie_pkg::FLT_STACK;
          else begin
            s_we = 1'b1; s_waddr = SAW'(sp_r - SPW'(2)); s_wdata = alu_res;
            sp_nxt = sp_r - SPW'(1); res_nxt.pc_offset = 16'sd1;
          end
        end else if (op == sbie_pkg::OP_INEG) begin
          if (sp_r < SPW'(1)) res_nxt.fault = sbie_pkg::FLT_STACK;
          else begin
            s_we = 1'b1; s_waddr = SAW'(sp_r - SPW'(1)); s_wdata = alu_res;
            res_nxt.pc_offset = 16'sd1;
          end
        end else if (op >= sbie_pkg::OP_IFEQ && op <= sbie_pkg::OP_IFLE) begin
          if (sp_r < SPW'(1)) res_nxt.fault = sbie_pkg::FLT_STACK;
          else begin
            sp_nxt = sp_r - SPW'(1); res_nxt.pc_offset = tk ? off16 : 16'sd3;
          end
        end else if (op >= sbie_pkg::OP_IF_ICMPEQ && op <= sbie_pkg::OP_IF_ICMPLE) begin
          if (sp_r < SPW'(2)) res_nxt.fault = sbie_pkg::FLT_STACK;
          else begin
            sp_nxt = sp_r - SPW'(2); res_nxt.pc_offset = tk ? off16 : 16'sd3;
          end
        end else if (op == sbie_pkg::OP_GOTO) begin
          res_nxt.pc_offset = off16;
        end else if (op == sbie_pkg::OP_IRETURN) begin
          if (sp_r < SPW'(1)) res_nxt.fault = sbie_pkg::FLT_STACK;
          else begin
            res_nxt.return_value = s_top; res_nxt.has_return = 1'b1;
            res_nxt.finished = 1'b1; sp_nxt = '0;
          end
        end else if (op == sbie_pkg::OP_RETURN) begin
          res_nxt.finished = 1'b1; sp_nxt = '0;
        end else if (op == sbie_pkg::OP_GETSTAT) begin
          res_nxt.pc_offset = 16'sd3;
        end else if (op == sbie_pkg::OP_INVVIRT) begin
          if (sp_r < SPW'(1)) res_nxt.fault = sbie_pkg::FLT_STACK;
          else begin
            res_nxt.print_value = s_top; res_nxt.print_valid = 1'b1;
            sp_nxt = sp_r - SPW'(1); res_nxt.pc_offset = 16'sd3;
          end
        end else begin
          res_nxt.fault = sbie_pkg::FLT_OPC;
        end
      end
      sbie_pkg::ST_DIV: begin
        // one quotient bit per cycle on magnitudes
        dq_nxt = {dq_r[30:0], !dtrial[32]};
        drem_nxt = dtrial[32] ? {drem_r[30:0], dq_r[31]} : dtrial[31:0];
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd31) begin
          state_nxt = sbie_pkg::ST_DONE;
          s_we = 1'b1; s_waddr = SAW'(sp_r - SPW'(2));
          if (op == sbie_pkg::OP_IDIV)
            s_wdata = qneg_r ? 32'd0 - dq_nxt : dq_nxt;
          else
            s_wdata = rneg_r ? 32'd0 - drem_nxt : drem_nxt;
          sp_nxt = sp_r - SPW'(1);
          res_nxt = '0; res_nxt.pc_offset = 16'sd1;
        end
      end
      sbie_pkg::ST_DONE: if (out_ready) state_nxt = sbie_pkg::ST_IDLE;
      default: state_nxt = sbie_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbie_pkg::ST_IDLE;
      sp_r <= '0;
      clr_r <= '0;
      stack_limit_r <= 7'd64;
      locals_limit_r <= 9'd256;
    end else begin
      state_r <= state_nxt;
      sp_r <= sp_nxt;
      if (clearing) clr_r <= clr_r + CW'(1);
      if (cfg_we) begin
        case (cfg_index)
          sbie_pkg::CFG_STACK_LIMIT:  stack_limit_r <= cfg_data[6:0];
          sbie_pkg::CFG_LOCALS_LIMIT: locals_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) ins_r <= in_data;
    res_r <= res_nxt;
    dq_r <= dq_nxt; drem_r <= drem_nxt; dcnt_r <= dcnt_nxt;
    if (state_r == sbie_pkg::ST_EXEC) begin
      dden_r <= s_top[31] ? 32'd0 - s_top : s_top;
      qneg_r <= s_top[31] ^ s_nxt[31];
      rneg_r <= s_nxt[31];
    end
  end

  assign out_valid = (state_r == sbie_pkg::ST_DONE);
  assign out_data = res_r;
endmodule

### src/sbie_ram.sv
// ----------------------------------------------------------------------------
// sbie_ram: generic single write, dual read RAM
// registered read data
// ----------------------------------------------------------------------------
module sbie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

### src/sbie_checker.sv
// ----------------------------------------------------------------------------
// sbie_checker: port-level assertions
// result ordering and field consistency seen at the ports
// ----------------------------------------------------------------------------
module sbie_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sbie_pkg::out_word_t out_data
);
  // no new word while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  // an accepted word is not followed at once by a valid result
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // a faulting result has zero pc_offset and neither finished nor print_valid
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.fault != sbie_pkg::FLT_NONE) |->
      (out_data.pc_offset == 16'sd0 && !out_data.finished && !out_data.print_valid))
    else $error("fault with side fields");
  // has_return implies finished
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.has_return) |-> out_data.finished)
    else $error("return without finish");
endmodule

bind stack_bytecode_int_execute sbie_checker u_sbie_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
